// ----- rtl/mtz_pkg.sv -----
// Shared constants and helpers for the min trailing zero grid path block.
`timescale 1ns / 1ps
package mtz_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 11;
  localparam int CMP_W    = (SIZE_W > ADDR_W + 1) ? SIZE_W : ADDR_W + 1;
  localparam int CELL_W   = 31;
  localparam int SUM_W    = 16;
  localparam int TWO_W    = 5;   // at most 30 factors of 2 in 31 bits
  localparam int FIVE_W   = 4;   // at most 13 factors of 5 in 31 bits

  // Exact division by 5: v * inverse mod 2^32 lands at or below the limit
  // only when 5 divides v, and then it is the quotient itself.
  localparam logic [31:0] INV5     = 32'hCCCC_CCCD;
  localparam logic [31:0] DIV5_LIM = 32'h3333_3333;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Trailing zeros of a nonzero nibble.
  function automatic logic [1:0] nibble_tz(input logic [3:0] n);
    logic [1:0] r;
    if (n[0])      r = 2'd0;
    else if (n[1]) r = 2'd1;
    else if (n[2]) r = 2'd2;
    else           r = 2'd3;
    return r;
  endfunction

endpackage

// ----- rtl/min_trailing_zero_grid_path.sv -----
// Top level: factor counting, row buffer update and result register.
`timescale 1ns / 1ps
// Minimum trailing-zero path over an N by N grid.
// Input stream s_axis: one beat per cell, row-major order; cell value in
// tdata[30:0]. Output stream m_axis: one beat after the last cell of each
// grid, carrying the min of the two path totals, the best factor-2 total
// and the best factor-5 total. cfg_wr_en/cfg_wr_data set the side length N
// (0 acts as 1, values above 1024 act as 1024) and restart the grid.
// From accept to the next tready each cell goes through these steps: the
// factor-of-5 count runs one exact division by 5 per cycle (one 32-bit
// multiply, at most 13 divisions), the factor-of-2 count strips one nibble
// per cycle, then the update state adds the counts to the smaller of the
// buffered row entry and the left sum and writes the new sum to the row
// buffer memory. The row buffer read is issued when the cell is accepted.
// The result appears in m_axis in the cycle after the last cell's update.
// While a result waits on m_axis the block keeps accepting cells; only the
// next grid's last cell holds until the output register is free.
// Reset (rst, synchronous) clears the position, the left sums, the output
// valid and sets N to 1; the row buffer needs no clearing since each entry
// is written before it is read.
module min_trailing_zero_grid_path
  import mtz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,    // grid_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] cell_value, [31] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] min_zero_count,
                                      // [31:16] best_twos_total,
                                      // [47:32] best_fives_total
);

  typedef enum logic [1:0] {ST_IDLE, ST_COUNT, ST_UPDATE} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   row_index;
  logic [ADDR_W-1:0]   col_index;
  logic [SUM_W-1:0]    left_twos;
  logic [SUM_W-1:0]    left_fives;

  logic [CELL_W-1:0]   v2;
  logic [CELL_W-1:0]   v5;
  logic [TWO_W-1:0]    cnt2;
  logic [FIVE_W-1:0]   cnt5;
  logic                done2;
  logic                done5;

  logic [2*SUM_W-1:0]  row_mem [MAX_SIZE];
  logic [2*SUM_W-1:0]  rd_data;

  logic [CMP_W-1:0]    size_ext;
  logic [ADDR_W-1:0]   last_next;
  logic [31:0]         q5;
  logic                s_acc;
  logic                out_free;
  logic                last_cell;
  logic                out_load;
  logic [SUM_W-1:0]    up_twos;
  logic [SUM_W-1:0]    up_fives;
  logic [SUM_W-1:0]    base_twos;
  logic [SUM_W-1:0]    base_fives;
  logic [SUM_W:0]      sum_twos;
  logic [SUM_W:0]      sum_fives;
  logic [SUM_W-1:0]    st;
  logic [SUM_W-1:0]    sf;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last_cell     = (row_index == last_idx) && (col_index == last_idx);
  assign out_load      = (state == ST_UPDATE) && last_cell && out_free;

  // side length clamp, kept as the last valid index
  always_comb begin
    size_ext = CMP_W'(cfg_wr_data);
    if (size_ext == '0) begin
      last_next = '0;
    end else if (size_ext > CMP_W'(MAX_SIZE)) begin
      last_next = ADDR_W'(MAX_SIZE - 1);
    end else begin
      last_next = ADDR_W'(size_ext - CMP_W'(1));
    end
  end

  assign q5 = {1'b0, v5} * INV5;

  always_comb begin
    up_twos  = rd_data[SUM_W-1:0];
    up_fives = rd_data[2*SUM_W-1:SUM_W];
    priority if (row_index == '0 && col_index == '0) begin
      base_twos  = '0;
      base_fives = '0;
    end else if (row_index == '0) begin
      base_twos  = left_twos;
      base_fives = left_fives;
    end else if (col_index == '0) begin
      base_twos  = up_twos;
      base_fives = up_fives;
    end else begin
      base_twos  = (up_twos < left_twos) ? up_twos : left_twos;
      base_fives = (up_fives < left_fives) ? up_fives : left_fives;
    end
    sum_twos  = {1'b0, base_twos} + (SUM_W + 1)'(cnt2);
    sum_fives = {1'b0, base_fives} + (SUM_W + 1)'(cnt5);
    st = sum_twos[SUM_W] ? SUM_MAX : sum_twos[SUM_W-1:0];
    sf = sum_fives[SUM_W] ? SUM_MAX : sum_fives[SUM_W-1:0];
  end

  // row buffer: read when a cell is taken, written back at its update
  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_data <= row_mem[col_index];
    end
    if (state == ST_UPDATE && (!last_cell || out_free)) begin
      row_mem[col_index] <= {sf, st};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_idx      <= '0;
      row_index     <= '0;
      col_index     <= '0;
      left_twos     <= '0;
      left_fives    <= '0;
      done2         <= 1'b0;
      done5         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // a new result may replace one leaving in the same cycle
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {sf, st, (st < sf) ? st : sf};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        last_idx  <= last_next;
        row_index <= '0;
        col_index <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            v2    <= s_axis_tdata[CELL_W-1:0];
            v5    <= s_axis_tdata[CELL_W-1:0];
            cnt2  <= '0;
            cnt5  <= '0;
            done2 <= (s_axis_tdata[CELL_W-1:0] == '0);
            done5 <= (s_axis_tdata[CELL_W-1:0] == '0);
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (!done2) begin
            if (v2[3:0] == 4'd0) begin
              v2   <= v2 >> 4;
              cnt2 <= cnt2 + TWO_W'(4);
            end else begin
              cnt2  <= cnt2 + TWO_W'(nibble_tz(v2[3:0]));
              done2 <= 1'b1;
            end
          end
          if (!done5) begin
            if (q5 <= DIV5_LIM) begin
              v5   <= q5[CELL_W-1:0];
              cnt5 <= cnt5 + FIVE_W'(1);
            end else begin
              done5 <= 1'b1;
            end
          end
          if (done2 && done5) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (!last_cell || out_free) begin
            left_twos  <= st;
            left_fives <= sf;
            state      <= ST_IDLE;
            if (col_index != last_idx) begin
              col_index <= col_index + ADDR_W'(1);
            end else begin
              col_index <= '0;
              if (row_index != last_idx) begin
                row_index <= row_index + ADDR_W'(1);
              end else begin
                row_index <= '0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mtz_checker.sv -----
// Port-level assertions for the min trailing zero grid path block.
`timescale 1ns / 1ps
module mtz_checker
  import mtz_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // min field is the smaller of the two totals
  a_min_field: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] ==
      ((m_axis_tdata[31:16] < m_axis_tdata[47:32]) ?
        m_axis_tdata[31:16] : m_axis_tdata[47:32]))
    else $error("min_zero_count disagrees with totals");

  // one cell at a time: no beat taken right after another
  a_one_cell: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("cell accepted while previous still in work");

endmodule

bind min_trailing_zero_grid_path mtz_checker u_mtz_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/min_trailing_zero_grid_path_tb.sv -----
// Testbench for the min trailing zero grid path block: directed rows, then random grids.
`timescale 1ns / 1ps
module min_trailing_zero_grid_path_tb;
  import mtz_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_CELLS = 270;
  localparam int SETTLE_CYCLES = 40;   // margin for the slowest cell plus the output stage
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [SUM_W-1:0] fives_total;     // tdata[47:32]
    logic [SUM_W-1:0] twos_total;      // tdata[31:16]
    logic [SUM_W-1:0] min_zeros;       // tdata[15:0]
  } path_cost_t;

  typedef enum bit {ROW_CELL, ROW_SIZE} row_kind_t;
  typedef enum bit {TX_STREAM, TX_BURSTY} tx_mode_t;
  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_LONG_STALL} rx_mode_t;

  typedef struct {
    row_kind_t       kind;
    logic [CELL_W-1:0] value;
    bit              typed;
    path_cost_t      want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;       // [30:0] cell_value, [31] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;            // [15:0] min_zero_count, [31:16] best_twos_total,
                                        // [47:32] best_fives_total

  always #CLK_HALF clk = ~clk;

  min_trailing_zero_grid_path dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Path-sum predictor state
  logic [SUM_W-1:0]  prev_row_twos [MAX_SIZE];
  logic [SUM_W-1:0]  prev_row_fives [MAX_SIZE];
  logic [SUM_W-1:0]  left_twos_sum;
  logic [SUM_W-1:0]  left_fives_sum;
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [SIZE_W-1:0] side_reg;

  path_cost_t expected_costs[$];
  int         errors = 0;
  tx_mode_t   tx_mode = TX_BURSTY;
  rx_mode_t   rx_mode = RX_STEADY;
  int         burst_left = 0;
  int         rx_hold = 0;
  int         idle_cycles = 0;

  function automatic int unsigned count_factor(input logic [CELL_W-1:0] v,
                                               input int unsigned p);
    logic [31:0] x;
    int unsigned n;
    x = v;
    n = 0;
    if (x == 0) return 0;  // zero cell carries no factors
    while (x % p == 0) begin
      x = x / p;
      n++;
    end
    return n;
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : SUM_W'(s);
  endfunction

  // Advances the path sums by one cell; returns 1 when the cell closes a grid.
  function automatic bit walk_cell(input logic [CELL_W-1:0] v, output path_cost_t res);
    int unsigned n, c, t, f, up_t, up_f;
    logic [SUM_W-1:0] st, sf;
    n = side_reg;
    if (n == 0) n = 1;
    if (n > MAX_SIZE) n = MAX_SIZE;
    t = count_factor(v, 2);
    f = count_factor(v, 5);
    c = cur_col;
    if (c >= n) c = 0;
    if (cur_row >= n) cur_row = 0;
    if (cur_row == 0 && c == 0) begin
      st = sum_sat(0, t);
      sf = sum_sat(0, f);
    end else if (cur_row == 0) begin
      st = sum_sat(left_twos_sum, t);
      sf = sum_sat(left_fives_sum, f);
    end else if (c == 0) begin
      st = sum_sat(prev_row_twos[c], t);
      sf = sum_sat(prev_row_fives[c], f);
    end else begin
      up_t = prev_row_twos[c];
      up_f = prev_row_fives[c];
      st = sum_sat((up_t < left_twos_sum) ? up_t : left_twos_sum, t);
      sf = sum_sat((up_f < left_fives_sum) ? up_f : left_fives_sum, f);
    end
    prev_row_twos[c]  = st;
    prev_row_fives[c] = sf;
    left_twos_sum     = st;
    left_fives_sum    = sf;
    res = '0;
    if (c + 1 < n) begin
      cur_col = c + 1;
      return 1'b0;
    end
    cur_col = 0;
    if (cur_row + 1 < n) begin
      cur_row++;
      return 1'b0;
    end
    cur_row = 0;
    res.min_zeros   = (st < sf) ? st : sf;
    res.twos_total  = st;
    res.fives_total = sf;
    return 1'b1;
  endfunction

  // Mostly 2^a * 5^b * m with m coprime to 10, plus zeros and raw words.
  function automatic logic [CELL_W-1:0] rand_cell();
    logic [63:0] v;
    int unsigned pick, a, b, m;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 30) return CELL_W'($urandom);
    a = $urandom_range(0, 30);
    b = $urandom_range(0, 13);
    v = 64'd1 << a;
    repeat (b) if (v * 5 <= 64'h7FFF_FFFF) v = v * 5;
    m = $urandom_range(1, 999);
    if (m % 2 == 0) m++;
    if (m % 5 == 0) m += 2;
    if (v * m <= 64'h7FFF_FFFF) v = v * m;
    return v[CELL_W-1:0];
  endfunction

  // Sender: one cell per call, bursts and gaps decided after each beat
  task automatic send_cell(input logic [CELL_W-1:0] v, input bit typed, input path_cost_t want);
    path_cost_t res;
    bit done;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v};
    do @(posedge clk); while (!s_axis_tready);
    done = walk_cell(v, res);
    if (typed) expected_costs.push_back(want);
    else if (done) expected_costs.push_back(res);
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [SIZE_W-1:0] n);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    side_reg = n;
    cur_row  = 0;
    cur_col  = 0;
  endtask

  task automatic send_random_cells(input int count);
    repeat (count) send_cell(rand_cell(), 1'b0, '0);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 30);
        end
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    path_cost_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_costs.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_costs.pop_front();
        if (got.min_zeros !== want.min_zeros) begin
          $error("min_zero_count: expected %0d, got %0d", want.min_zeros, got.min_zeros);
          errors++;
        end
        if (got.twos_total !== want.twos_total) begin
          $error("best_twos_total: expected %0d, got %0d", want.twos_total, got.twos_total);
          errors++;
        end
        if (got.fives_total !== want.fives_total) begin
          $error("best_fives_total: expected %0d, got %0d",
                 want.fives_total, got.fives_total);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[$];

  function automatic void add_row(input row_kind_t kind, input logic [CELL_W-1:0] v,
                                  input bit typed, input int unsigned mz,
                                  input int unsigned tw, input int unsigned fv);
    dir_row_t r;
    r.kind  = kind;
    r.value = v;
    r.typed = typed;
    r.want.min_zeros   = SUM_W'(mz);
    r.want.twos_total  = SUM_W'(tw);
    r.want.fives_total = SUM_W'(fv);
    dir_rows.push_back(r);
  endfunction

  initial begin
    int sent, side, grids, cells;
    side_reg       = 1;
    cur_row        = 0;
    cur_col        = 0;
    left_twos_sum  = '0;
    left_fives_sum = '0;
    foreach (prev_row_twos[i]) begin
      prev_row_twos[i]  = '0;
      prev_row_fives[i] = '0;
    end

    // Side 1 after reset: every cell is a whole grid
    add_row(ROW_CELL, 31'd0, 1'b1, 0, 0, 0);            // zero cell
    add_row(ROW_CELL, 31'h7FFF_FFFF, 1'b1, 0, 0, 0);
    add_row(ROW_CELL, 31'h4000_0000, 1'b1, 0, 30, 0);   // most twos
    add_row(ROW_CELL, 31'd1220703125, 1'b1, 0, 0, 13);  // 5^13, most fives
    add_row(ROW_CELL, 31'd1000000000, 1'b1, 9, 9, 9);
    add_row(ROW_CELL, 31'd1, 1'b1, 0, 0, 0);
    add_row(ROW_CELL, 31'h5555_5555, 1'b1, 0, 0, 1);
    add_row(ROW_SIZE, 31'd0, 1'b0, 0, 0, 0);            // side 0 acts as 1
    add_row(ROW_CELL, 31'd40, 1'b1, 1, 3, 1);
    add_row(ROW_SIZE, 31'd2, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd2, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd5, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd10, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd4, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd8, 1'b0, 0, 0, 0);            // grid cut short by the rewrite
    add_row(ROW_CELL, 31'd25, 1'b0, 0, 0, 0);
    add_row(ROW_SIZE, 31'd2, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd1, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd50, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd20, 1'b0, 0, 0, 0);
    add_row(ROW_CELL, 31'd1000, 1'b0, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) write_side(SIZE_W'(dir_rows[i].value));
      else send_cell(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end

    sent = 0;
    while (sent < RANDOM_CELLS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: side = $urandom_range(1, 5);
        15, 16, 17, 18: side = $urandom_range(6, 10);
        default: side = $urandom_range(11, 16);
      endcase
      write_side(SIZE_W'(side));
      tx_mode <= ($urandom_range(0, 3) == 0) ? TX_STREAM : TX_BURSTY;
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      grids = $urandom_range(1, 4);
      repeat (grids) begin
        cells = side * side;
        // occasionally leave a grid unfinished so the next size write restarts it
        if (side > 1 && $urandom_range(0, 9) == 0) cells = $urandom_range(1, cells - 1);
        if (cells > RANDOM_CELLS - sent) cells = RANDOM_CELLS - sent;
        send_random_cells(cells);
        sent += cells;
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
    end

    // Largest side, and an oversize value that clamps to it: partial grids only
    tx_mode <= TX_STREAM;
    rx_mode <= RX_STEADY;
    write_side(SIZE_W'(MAX_SIZE));
    send_random_cells(MAX_SIZE + 6);
    write_side('1);
    send_random_cells(20);
    tx_mode <= TX_BURSTY;
    rx_mode <= RX_LONG_STALL;
    write_side(SIZE_W'(3));
    send_random_cells(18);

    wait_drained();
    if (errors == 0 && expected_costs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mtz_pkg.sv
rtl/min_trailing_zero_grid_path.sv
rtl/mtz_checker.sv
tb/min_trailing_zero_grid_path_tb.sv
